/* hdl/m6502_pkg.sv */
// m6502_pkg: shared types, constants and decode helpers for the 6502 core.
// No dependencies; used by m6502_exec and mos6502_cpu_core.
`timescale 1ns / 1ps

package m6502_pkg;

  localparam logic [15:0] VecResLo = 16'hFFFC;
  localparam logic [15:0] VecResHi = 16'hFFFD;
  localparam logic [15:0] VecBrkLo = 16'hFFFE;
  localparam logic [15:0] VecBrkHi = 16'hFFFF;
  localparam logic [7:0]  StackPage = 8'h01;
  localparam logic [7:0]  SpReset   = 8'hFD;
  localparam logic [7:0]  PReset    = 8'h24;
  localparam logic [7:0]  SignBit   = 8'h80;

  typedef struct packed {
    logic       operation;
    logic [7:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] bus_address;
    logic [7:0]  bus_write_data;
    logic        bus_write;
    logic        opcode_fetch;
  } out_item_t;

  typedef enum logic [4:0] {
    M_IMP, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY, M_IZX, M_IZY,
    M_REL, M_BRK, M_JSR, M_RTI, M_RTS, M_PUSH, M_PULL, M_JMP, M_JMPI
  } mode_e;

  typedef enum logic [4:0] {
    F_ORA, F_AND, F_EOR, F_ADC, F_STA, F_LDA, F_CMP, F_SBC,
    F_ASL, F_ROL, F_LSR, F_ROR, F_STX, F_LDX, F_DEC, F_INC,
    F_G0, F_BIT, F_G2, F_G3, F_STY, F_LDY, F_CPY, F_CPX, F_NONE
  } func_e;

  typedef enum logic [1:0] {K_READ, K_WRITE, K_RMW} kind_e;

  // Reset vector fetch phases, one-hot.
  typedef enum logic [3:0] {
    VP_RUN = 4'b0001, VP_LO = 4'b0010, VP_HI = 4'b0100, VP_LOAD = 4'b1000
  } vphase_e;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  p;
    logic [15:0] pc;
    logic [7:0]  op;
    logic [15:0] ea;
    logic [7:0]  lat;
    logic [2:0]  step;
    logic        icarry;
  } cpu_state_t;

  function automatic mode_e dec_mode(input logic [7:0] op);
    logic [2:0] a, b;
    logic [1:0] cc;
    mode_e m;
    a = op[7:5]; b = op[4:2]; cc = op[1:0];
    m = M_IMP;
    case (cc)
      2'd1: begin
        if (op != 8'h89) begin
          case (b)
            3'd0: m = M_IZX; 3'd1: m = M_ZP;  3'd2: m = M_IMM; 3'd3: m = M_ABS;
            3'd4: m = M_IZY; 3'd5: m = M_ZPX; 3'd6: m = M_ABY; default: m = M_ABX;
          endcase
        end
      end
      2'd2: begin
        if (b == 3'd0) m = (op == 8'hA2) ? M_IMM : M_IMP;
        else if (b == 3'd2 || b == 3'd4 || b == 3'd6 || op == 8'h9E) m = M_IMP;
        else if (b == 3'd5) m = (a == 3'd4 || a == 3'd5) ? M_ZPY : M_ZPX;
        else if (b == 3'd7) m = (a == 3'd5) ? M_ABY : M_ABX;
        else m = (b == 3'd1) ? M_ZP : M_ABS;
      end
      2'd0: begin
        case (b)
          3'd0: begin
            if (op == 8'h00) m = M_BRK;
            else if (op == 8'h20) m = M_JSR;
            else if (op == 8'h40) m = M_RTI;
            else if (op == 8'h60) m = M_RTS;
            else if (a >= 3'd5) m = M_IMM;
          end
          3'd1: if (a == 3'd1 || a >= 3'd4) m = M_ZP;
          3'd2: begin
            if (op == 8'h08 || op == 8'h48) m = M_PUSH;
            else if (op == 8'h28 || op == 8'h68) m = M_PULL;
          end
          3'd3: begin
            if (op == 8'h4C) m = M_JMP;
            else if (op == 8'h6C) m = M_JMPI;
            else if (a == 3'd1 || a >= 3'd4) m = M_ABS;
          end
          3'd4: m = M_REL;
          3'd5: if (a == 3'd4 || a == 3'd5) m = M_ZPX;
          3'd7: if (op == 8'hBC) m = M_ABX;
          default: m = M_IMP;
        endcase
      end
      default: m = M_IMP;
    endcase
    return m;
  endfunction

  function automatic func_e dec_func(input logic [7:0] op);
    logic [2:0] a, b;
    logic [1:0] cc;
    func_e f;
    a = op[7:5]; b = op[4:2]; cc = op[1:0];
    f = F_NONE;
    case (cc)
      2'd1: if (op != 8'h89) f = func_e'({2'b00, a});
      2'd2: begin
        if (b == 3'd0) begin
          if (op == 8'hA2) f = F_LDX;
        end else if (!(b == 3'd2 || b == 3'd4 || b == 3'd6 || op == 8'h9E)) begin
          f = func_e'({2'b01, a});
        end
      end
      2'd0: begin
        case (b)
          3'd0: if (a >= 3'd5 && op != 8'h00 && op != 8'h20 && op != 8'h40 && op != 8'h60)
            f = func_e'({2'b10, a});
          3'd1: if (a == 3'd1 || a >= 3'd4) f = func_e'({2'b10, a});
          3'd3: if ((a == 3'd1 || a >= 3'd4) && op != 8'h4C && op != 8'h6C)
            f = func_e'({2'b10, a});
          3'd5: if (a == 3'd4 || a == 3'd5) f = func_e'({2'b10, a});
          3'd7: if (op == 8'hBC) f = F_LDY;
          default: f = F_NONE;
        endcase
      end
      default: f = F_NONE;
    endcase
    return f;
  endfunction

  function automatic kind_e kind_of(input func_e f);
    kind_e k;
    k = K_READ;
    if (f == F_STA || f == F_STX || f == F_STY) k = K_WRITE;
    else if (f >= F_ASL && f <= F_INC && f != F_LDX) k = K_RMW;
    return k;
  endfunction

endpackage

/* hdl/mos6502_cpu_core.sv */
// 6502 CPU core (no decimal mode, no interrupts). Each input transaction is one
// bus tick: it delivers the byte read by the previous access and yields the next
// access as one output transaction, so one tick per clock while not stalled.
// A tick with operation set restarts the reset vector fetch (FFFC, FFFD, opcode).
// Instruction timing follows the NMOS part.
// Depends on m6502_pkg and m6502_exec.
`timescale 1ns / 1ps

module mos6502_cpu_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  m6502_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output m6502_pkg::out_item_t  out_data_o
);
  import m6502_pkg::*;

  localparam cpu_state_t StReset = '{sp: SpReset, p: PReset, default: '0};

  cpu_state_t st_q, st_d, run_st, src_st;
  out_item_t  out_q, out_d, run_bus;
  vphase_e    vp_q, vp_d, vp_cur;
  logic       out_vld_q;
  logic       take;

  assign in_ready_o = !out_vld_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  assign src_st = in_data_i.operation ? StReset : st_q;
  assign vp_cur = in_data_i.operation ? VP_LO : vp_q;

  m6502_exec u_exec (
    .s_i  (src_st),
    .d_i  (in_data_i.read_data),
    .s_o  (run_st),
    .bus_o(run_bus)
  );

  always_comb begin
    st_d  = src_st;
    out_d = '0;
    vp_d  = vp_cur;
    case (vp_cur)
      VP_LO: begin
        out_d.bus_address = VecResLo;
        vp_d = VP_HI;
      end
      VP_HI: begin
        st_d.ea = {8'h00, in_data_i.read_data};
        out_d.bus_address = VecResHi;
        vp_d = VP_LOAD;
      end
      VP_LOAD: begin
        out_d = '{{in_data_i.read_data, src_st.ea[7:0]}, 8'h00, 1'b0, 1'b1};
        st_d.pc = {in_data_i.read_data, src_st.ea[7:0]} + 16'd1;
        st_d.step = 3'd0;
        vp_d = VP_RUN;
      end
      default: begin
        st_d  = run_st;
        out_d = run_bus;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StReset;
      vp_q      <= VP_LO;
      out_vld_q <= 1'b0;
    end else begin
      if (take) begin
        st_q <= st_d;
        vp_q <= vp_d;
      end
      if (take) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |=> $stable(out_q))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_ready_o)
    else $error("input blocked with empty output");
  a_flag_b5: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.p[5] && !st_q.p[4])
    else $error("status bits 5/4 corrupted");
  a_vec_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && in_data_i.operation |=> out_q.bus_address == VecResLo)
    else $error("reset tick did not read low vector");
  a_write_no_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.bus_write |-> !out_q.opcode_fetch)
    else $error("write marked as opcode fetch");
`endif

endmodule

/* hdl/m6502_exec.sv */
// m6502_exec: combinational next-state and bus-access logic for one tick.
// Depends on m6502_pkg.
`timescale 1ns / 1ps

module m6502_exec (
  input  m6502_pkg::cpu_state_t s_i,
  input  logic [7:0]            d_i,
  output m6502_pkg::cpu_state_t s_o,
  output m6502_pkg::out_item_t  bus_o
);
  import m6502_pkg::*;

  cpu_state_t s;
  out_item_t  b;
  mode_e      mode;
  func_e      fn;
  logic [7:0] cur_op;
  logic [2:0] n;
  logic [2:0] k;
  logic [8:0] sum9;
  logic [15:0] rel_t;
  logic       br_set;
  logic [7:0] mres;
  logic       do_mem;
  logic [2:0] mk;
  kind_e      kind;

  function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] r;
    r = p;
    r[1] = (v == 8'h00);
    r[7] = v[7];
    return r;
  endfunction

  always_comb begin
    s = s_i;
    b = '0;
    do_mem = 1'b0;
    mk = 3'd0;
    sum9 = '0;
    rel_t = '0;
    br_set = 1'b0;
    mres = '0;
    k = 3'd0;
    cur_op = (s_i.step == 3'd0) ? d_i : s_i.op;
    s.op = cur_op;
    mode = dec_mode(cur_op);
    fn = dec_func(cur_op);
    kind = kind_of(fn);
    n = s_i.step + 3'd1;
    s.step = n;

    case (mode)
      M_IMP: begin
        if (n == 3'd1) begin
          b.bus_address = s.pc;
          case (cur_op)
            8'h0A, 8'h2A, 8'h4A, 8'h6A: begin
              case (cur_op[6:5])
                2'd0: begin mres = {s.a[6:0], 1'b0}; s.p[0] = s.a[7]; end
                2'd1: begin mres = {s.a[6:0], s_i.p[0]}; s.p[0] = s.a[7]; end
                2'd2: begin mres = {1'b0, s.a[7:1]}; s.p[0] = s.a[0]; end
                default: begin mres = {s_i.p[0], s.a[7:1]}; s.p[0] = s.a[0]; end
              endcase
              s.a = mres; s.p = nz(s.p, mres);
            end
            8'h8A: begin s.a = s.x; s.p = nz(s.p, s.x); end
            8'h98: begin s.a = s.y; s.p = nz(s.p, s.y); end
            8'hAA: begin s.x = s.a; s.p = nz(s.p, s.a); end
            8'hA8: begin s.y = s.a; s.p = nz(s.p, s.a); end
            8'hBA: begin s.x = s.sp; s.p = nz(s.p, s.sp); end
            8'h9A: s.sp = s.x;
            8'hCA: begin s.x = s.x - 8'd1; s.p = nz(s.p, s.x); end
            8'hE8: begin s.x = s.x + 8'd1; s.p = nz(s.p, s.x); end
            8'h88: begin s.y = s.y - 8'd1; s.p = nz(s.p, s.y); end
            8'hC8: begin s.y = s.y + 8'd1; s.p = nz(s.p, s.y); end
            8'h18: s.p[0] = 1'b0;
            8'h38: s.p[0] = 1'b1;
            8'h58: s.p[2] = 1'b0;
            8'h78: s.p[2] = 1'b1;
            8'hB8: s.p[6] = 1'b0;
            8'hD8: s.p[3] = 1'b0;
            8'hF8: s.p[3] = 1'b1;
            default: s.p = s.p;
          endcase
        end else k = 3'd7;
      end
      M_IMM: begin
        if (n == 3'd1) k = 3'd1;
        else begin do_mem = 1'b1; mk = 3'd1; end
      end
      M_ZP: begin
        if (n == 3'd1) k = 3'd1;
        else begin
          if (n == 3'd2) s.ea = {8'h00, d_i};
          do_mem = 1'b1; mk = n - 3'd2;
        end
      end
      M_ZPX, M_ZPY: begin
        if (n == 3'd1) k = 3'd1;
        else if (n == 3'd2) begin
          b.bus_address = {8'h00, d_i};
          s.ea = {8'h00, d_i + ((mode == M_ZPX) ? s.x : s.y)};
        end else begin do_mem = 1'b1; mk = n - 3'd3; end
      end
      M_ABS: begin
        if (n == 3'd1) k = 3'd1;
        else if (n == 3'd2) begin s.ea = {8'h00, d_i}; k = 3'd1; end
        else begin
          if (n == 3'd3) s.ea[15:8] = d_i;
          do_mem = 1'b1; mk = n - 3'd3;
        end
      end
      M_ABX, M_ABY, M_IZY: begin
        if (n == 3'd1) k = 3'd1;
        else if (mode != M_IZY && n == 3'd2) begin s.ea = {8'h00, d_i}; k = 3'd1; end
        else if (mode == M_IZY && n == 3'd2) begin
          s.lat = d_i; b.bus_address = {8'h00, d_i};
        end else if (mode == M_IZY && n == 3'd3) begin
          s.ea = {8'h00, d_i}; b.bus_address = {8'h00, s.lat + 8'd1};
        end else if ((mode != M_IZY && n == 3'd3) || (mode == M_IZY && n == 3'd4)) begin
          sum9 = {1'b0, s.ea[7:0]} + {1'b0, (mode == M_ABX) ? s.x : s.y};
          s.icarry = sum9[8];
          s.ea = {d_i, sum9[7:0]};
          b.bus_address = s.ea;
        end else begin
          mk = n - ((mode == M_IZY) ? 3'd5 : 3'd4);
          if (kind == K_READ && !s_i.icarry) mk = mk + 3'd1;
          else if (mk == 3'd0 && s_i.icarry) s.ea = s.ea + 16'h0100;
          do_mem = 1'b1;
        end
      end
      M_IZX: begin
        if (n == 3'd1) k = 3'd1;
        else if (n == 3'd2) begin b.bus_address = {8'h00, d_i}; s.lat = d_i + s.x; end
        else if (n == 3'd3) b.bus_address = {8'h00, s.lat};
        else if (n == 3'd4) begin
          s.ea = {8'h00, d_i}; b.bus_address = {8'h00, s.lat + 8'd1};
        end else begin
          if (n == 3'd5) s.ea[15:8] = d_i;
          do_mem = 1'b1; mk = n - 3'd5;
        end
      end
      M_REL: begin
        if (n == 3'd1) k = 3'd1;
        else if (n == 3'd2) begin
          case (cur_op[7:6])
            2'd0: br_set = s.p[7];
            2'd1: br_set = s.p[6];
            2'd2: br_set = s.p[0];
            default: br_set = s.p[1];
          endcase
          if (br_set != cur_op[5]) k = 3'd7;
          else begin
            b.bus_address = s.pc;
            rel_t = s.pc + {{8{d_i[7]}}, d_i};
            s.ea = rel_t;
            s.icarry = (rel_t[15:8] != s.pc[15:8]);
            s.pc = {s.pc[15:8], rel_t[7:0]};
          end
        end else if (n == 3'd3 && s_i.icarry) begin
          b.bus_address = s.pc; s.pc = s.ea;
        end else k = 3'd7;
      end
      M_BRK: begin
        case (n)
          3'd1: k = 3'd1;
          3'd2: begin b = '{{StackPage, s.sp}, s.pc[15:8], 1'b1, 1'b0}; s.sp = s.sp - 8'd1; end
          3'd3: begin b = '{{StackPage, s.sp}, s.pc[7:0], 1'b1, 1'b0}; s.sp = s.sp - 8'd1; end
          3'd4: begin
            b = '{{StackPage, s.sp}, s.p | 8'h30, 1'b1, 1'b0};
            s.sp = s.sp - 8'd1; s.p[2] = 1'b1;
          end
          3'd5: b.bus_address = VecBrkLo;
          3'd6: begin s.ea = {8'h00, d_i}; b.bus_address = VecBrkHi; end
          default: begin s.pc = {d_i, s.ea[7:0]}; k = 3'd7; end
        endcase
      end
      M_JSR: begin
        case (n)
          3'd1: k = 3'd1;
          3'd2: begin s.lat = d_i; b.bus_address = {StackPage, s.sp}; end
          3'd3: begin b = '{{StackPage, s.sp}, s.pc[15:8], 1'b1, 1'b0}; s.sp = s.sp - 8'd1; end
          3'd4: begin b = '{{StackPage, s.sp}, s.pc[7:0], 1'b1, 1'b0}; s.sp = s.sp - 8'd1; end
          3'd5: b.bus_address = s.pc;
          default: begin s.pc = {d_i, s.lat}; k = 3'd7; end
        endcase
      end
      M_RTI, M_RTS: begin
        case (n)
          3'd1: b.bus_address = s.pc;
          3'd2, 3'd3: begin b.bus_address = {StackPage, s.sp}; s.sp = s.sp + 8'd1; end
          3'd4: begin
            if (mode == M_RTI) begin
              s.p = (d_i & 8'hCF) | 8'h20;
              b.bus_address = {StackPage, s.sp}; s.sp = s.sp + 8'd1;
            end else begin
              s.ea = {8'h00, d_i}; b.bus_address = {StackPage, s.sp};
            end
          end
          3'd5: begin
            if (mode == M_RTI) begin
              s.ea = {8'h00, d_i}; b.bus_address = {StackPage, s.sp};
            end else begin
              s.pc = {d_i, s.ea[7:0]}; k = 3'd1;
            end
          end
          default: begin
            if (mode == M_RTI) s.pc = {d_i, s.ea[7:0]};
            k = 3'd7;
          end
        endcase
      end
      M_PUSH: begin
        if (n == 3'd1) b.bus_address = s.pc;
        else if (n == 3'd2) begin
          b = '{{StackPage, s.sp}, (cur_op == 8'h48) ? s.a : (s.p | 8'h30), 1'b1, 1'b0};
          s.sp = s.sp - 8'd1;
        end else k = 3'd7;
      end
      M_PULL: begin
        if (n == 3'd1) b.bus_address = s.pc;
        else if (n == 3'd2) begin b.bus_address = {StackPage, s.sp}; s.sp = s.sp + 8'd1; end
        else if (n == 3'd3) b.bus_address = {StackPage, s.sp};
        else begin
          if (cur_op == 8'h68) begin s.a = d_i; s.p = nz(s.p, d_i); end
          else s.p = (d_i & 8'hCF) | 8'h20;
          k = 3'd7;
        end
      end
      M_JMP: begin
        if (n == 3'd1) k = 3'd1;
        else if (n == 3'd2) begin s.lat = d_i; b.bus_address = s.pc; end
        else begin s.pc = {d_i, s.lat}; k = 3'd7; end
      end
      default: begin
        if (n == 3'd1) k = 3'd1;
        else if (n == 3'd2) begin s.ea = {8'h00, d_i}; k = 3'd1; end
        else if (n == 3'd3) begin s.ea[15:8] = d_i; b.bus_address = s.ea; end
        else if (n == 3'd4) begin
          s.lat = d_i; b.bus_address = {s.ea[15:8], s.ea[7:0] + 8'd1};
        end else begin s.pc = {d_i, s.lat}; k = 3'd7; end
      end
    endcase

    // operand access phases
    if (do_mem) begin
      case (kind)
        K_READ: begin
          if (mk == 3'd0) b.bus_address = s.ea;
          else begin
            case (fn)
              F_ORA: begin s.a = s.a | d_i; s.p = nz(s.p, s.a); end
              F_AND: begin s.a = s.a & d_i; s.p = nz(s.p, s.a); end
              F_EOR: begin s.a = s.a ^ d_i; s.p = nz(s.p, s.a); end
              F_ADC, F_SBC: begin
                mres = (fn == F_SBC) ? ~d_i : d_i;
                sum9 = {1'b0, s.a} + {1'b0, mres} + {8'h00, s.p[0]};
                s.p[6] = ~(s.a[7] ^ mres[7]) & (s.a[7] ^ sum9[7]);
                s.p[0] = sum9[8];
                s.a = sum9[7:0];
                s.p = nz(s.p, s.a);
              end
              F_LDA: begin s.a = d_i; s.p = nz(s.p, d_i); end
              F_LDX: begin s.x = d_i; s.p = nz(s.p, d_i); end
              F_LDY: begin s.y = d_i; s.p = nz(s.p, d_i); end
              F_CMP, F_CPX, F_CPY: begin
                mres = (fn == F_CMP) ? s.a : ((fn == F_CPX) ? s.x : s.y);
                s.p[0] = (mres >= d_i);
                s.p = nz(s.p, mres - d_i);
              end
              F_BIT: begin
                s.p[1] = ((s.a & d_i) == 8'h00);
                s.p[7] = d_i[7];
                s.p[6] = d_i[6];
              end
              default: s.p = s.p;
            endcase
            k = 3'd7;
          end
        end
        K_WRITE: begin
          if (mk == 3'd0) begin
            b.bus_address = s.ea;
            b.bus_write = 1'b1;
            b.bus_write_data = (fn == F_STA) ? s.a : ((fn == F_STX) ? s.x : s.y);
          end else k = 3'd7;
        end
        default: begin
          if (mk == 3'd0) b.bus_address = s.ea;
          else if (mk == 3'd1) begin
            s.lat = d_i; b = '{s.ea, d_i, 1'b1, 1'b0};
          end else if (mk == 3'd2) begin
            case (fn)
              F_ASL: begin mres = {s.lat[6:0], 1'b0}; s.p[0] = s.lat[7]; end
              F_ROL: begin mres = {s.lat[6:0], s_i.p[0]}; s.p[0] = s.lat[7]; end
              F_LSR: begin mres = {1'b0, s.lat[7:1]}; s.p[0] = s.lat[0]; end
              F_ROR: begin mres = {s_i.p[0], s.lat[7:1]}; s.p[0] = s.lat[0]; end
              F_DEC: mres = s.lat - 8'd1;
              F_INC: mres = s.lat + 8'd1;
              default: mres = s.lat;
            endcase
            s.p = nz(s.p, mres);
            s.lat = mres;
            b = '{s.ea, mres, 1'b1, 1'b0};
          end else k = 3'd7;
        end
      endcase
    end

    // k = 1: read at PC and advance; k = 7: fetch the next opcode
    if (k == 3'd1 || k == 3'd7) begin
      b = '{s.pc, 8'h00, 1'b0, (k == 3'd7)};
      s.pc = s.pc + 16'd1;
      if (k == 3'd7) s.step = 3'd0;
    end
  end

  assign s_o   = s;
  assign bus_o = b;

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking testbench for mos6502_cpu_core, one bus tick per transaction.
// Drives ticks with bus bytes generated up front, predicts every bus access.
// Depends on m6502_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
  import m6502_pkg::*;

  localparam int NumDirected = 25;
  localparam int NumTicks    = 825;
  localparam int CycleLimit  = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  mos6502_cpu_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  in_item_t  tick_q[$];
  out_item_t access_q[$];
  int        err_cnt = 0;
  int        sent_cnt = 0;
  int        seen_cnt = 0;
  int        cyc_cnt = 0;

  // ---------------- CPU shadow ----------------
  logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_s, cpu_p, cpu_op, cpu_lat;
  logic [15:0] cpu_pc, cpu_ea;
  logic [2:0]  cpu_step;
  int          vec_ph;
  bit          page_cross;
  out_item_t   bus_acc;

  localparam logic [7:0] FlC = 8'h01, FlZ = 8'h02, FlI = 8'h04, FlD = 8'h08;
  localparam logic [7:0] FlV = 8'h40, FlN = 8'h80;

  function automatic void cpu_clear();
    cpu_a = '0; cpu_x = '0; cpu_y = '0; cpu_s = SpReset; cpu_p = PReset;
    cpu_pc = '0; cpu_ea = '0; cpu_op = '0; cpu_lat = '0; cpu_step = '0;
    vec_ph = 1; page_cross = 0; bus_acc = '0;
  endfunction

  function automatic void rd(logic [15:0] adr);
    bus_acc = '0;
    bus_acc.bus_address = adr;
  endfunction

  function automatic void wr(logic [15:0] adr, logic [7:0] v);
    bus_acc = '0;
    bus_acc.bus_address = adr;
    bus_acc.bus_write_data = v;
    bus_acc.bus_write = 1'b1;
  endfunction

  function automatic void rd_pc();
    rd(cpu_pc);
    cpu_pc = cpu_pc + 16'd1;
  endfunction

  function automatic void fetch_op();
    rd_pc();
    bus_acc.opcode_fetch = 1'b1;
    cpu_step = '0;
  endfunction

  function automatic logic [15:0] sp_adr();
    return {StackPage, cpu_s};
  endfunction

  function automatic void put_flag(logic [7:0] m, bit on);
    cpu_p = on ? (cpu_p | m) : (cpu_p & ~m);
  endfunction

  function automatic void put_nz(logic [7:0] v);
    put_flag(FlZ, v == 8'h00);
    put_flag(FlN, v[7]);
  endfunction

  function automatic void decode_op(input logic [7:0] op, output mode_e m, output func_e f);
    logic [2:0] a, b;
    a = op[7:5]; b = op[4:2];
    m = M_IMP; f = F_NONE;
    case (op[1:0])
      2'd1: if (op != 8'h89) begin
        f = func_e'({2'b00, a});
        case (b)
          3'd0: m = M_IZX; 3'd1: m = M_ZP;  3'd2: m = M_IMM; 3'd3: m = M_ABS;
          3'd4: m = M_IZY; 3'd5: m = M_ZPX; 3'd6: m = M_ABY; default: m = M_ABX;
        endcase
      end
      2'd2: begin
        if (b == 3'd0) begin
          if (op == 8'hA2) begin
            m = M_IMM; f = F_LDX;
          end
        end else if (!(b == 3'd2 || b == 3'd4 || b == 3'd6 || op == 8'h9E)) begin
          f = func_e'({2'b01, a});
          if (b == 3'd5) m = (a == 3'd4 || a == 3'd5) ? M_ZPY : M_ZPX;
          else if (b == 3'd7) m = (a == 3'd5) ? M_ABY : M_ABX;
          else m = (b == 3'd1) ? M_ZP : M_ABS;
        end
      end
      2'd0: begin
        case (b)
          3'd0: begin
            if (op == 8'h00) m = M_BRK;
            else if (op == 8'h20) m = M_JSR;
            else if (op == 8'h40) m = M_RTI;
            else if (op == 8'h60) m = M_RTS;
            else if (a >= 3'd5) begin
              m = M_IMM; f = func_e'({2'b10, a});
            end
          end
          3'd1: if (a == 3'd1 || a >= 3'd4) begin
            m = M_ZP; f = func_e'({2'b10, a});
          end
          3'd2: begin
            if (op == 8'h08 || op == 8'h48) m = M_PUSH;
            else if (op == 8'h28 || op == 8'h68) m = M_PULL;
          end
          3'd3: begin
            if (op == 8'h4C) m = M_JMP;
            else if (op == 8'h6C) m = M_JMPI;
            else if (a == 3'd1 || a >= 3'd4) begin
              m = M_ABS; f = func_e'({2'b10, a});
            end
          end
          3'd4: m = M_REL;
          3'd5: if (a == 3'd4 || a == 3'd5) begin
            m = M_ZPX; f = func_e'({2'b10, a});
          end
          3'd7: if (op == 8'hBC) begin
            m = M_ABX; f = F_LDY;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endfunction

  function automatic kind_e access_kind(func_e f);
    if (f == F_STA || f == F_STX || f == F_STY) return K_WRITE;
    if (f >= F_ASL && f <= F_INC && f != F_LDX) return K_RMW;
    return K_READ;
  endfunction

  function automatic void add_c(logic [7:0] d);
    logic [8:0] sum;
    sum = {1'b0, cpu_a} + {1'b0, d} + {8'h00, cpu_p[0]};
    put_flag(FlV, (~(cpu_a[7] ^ d[7])) & (cpu_a[7] ^ sum[7]));
    put_flag(FlC, sum[8]);
    cpu_a = sum[7:0];
    put_nz(cpu_a);
  endfunction

  function automatic void cmp_reg(logic [7:0] r, logic [7:0] d);
    put_flag(FlC, r >= d);
    put_nz(r - d);
  endfunction

  function automatic void do_read(func_e f, logic [7:0] d);
    case (f)
      F_ORA: begin cpu_a = cpu_a | d; put_nz(cpu_a); end
      F_AND: begin cpu_a = cpu_a & d; put_nz(cpu_a); end
      F_EOR: begin cpu_a = cpu_a ^ d; put_nz(cpu_a); end
      F_ADC: add_c(d);
      F_SBC: add_c(~d);
      F_LDA: begin cpu_a = d; put_nz(d); end
      F_LDX: begin cpu_x = d; put_nz(d); end
      F_LDY: begin cpu_y = d; put_nz(d); end
      F_CMP: cmp_reg(cpu_a, d);
      F_CPX: cmp_reg(cpu_x, d);
      F_CPY: cmp_reg(cpu_y, d);
      F_BIT: begin
        put_flag(FlZ, (cpu_a & d) == 8'h00);
        put_flag(FlN, d[7]);
        put_flag(FlV, d[6]);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] shift_op(func_e f, logic [7:0] v);
    logic [7:0] r;
    logic c;
    c = cpu_p[0];
    case (f)
      F_ASL: begin r = {v[6:0], 1'b0}; put_flag(FlC, v[7]); end
      F_ROL: begin r = {v[6:0], c};    put_flag(FlC, v[7]); end
      F_LSR: begin r = {1'b0, v[7:1]}; put_flag(FlC, v[0]); end
      F_ROR: begin r = {c, v[7:1]};    put_flag(FlC, v[0]); end
      F_DEC: r = v - 8'd1;
      F_INC: r = v + 8'd1;
      default: r = v;
    endcase
    put_nz(r);
    return r;
  endfunction

  function automatic void do_implied(logic [7:0] op);
    case (op)
      8'h0A, 8'h2A, 8'h4A, 8'h6A: cpu_a = shift_op(func_e'({2'b01, op[7:5]}), cpu_a);
      8'h8A: begin cpu_a = cpu_x; put_nz(cpu_a); end
      8'h98: begin cpu_a = cpu_y; put_nz(cpu_a); end
      8'hAA: begin cpu_x = cpu_a; put_nz(cpu_x); end
      8'hA8: begin cpu_y = cpu_a; put_nz(cpu_y); end
      8'hBA: begin cpu_x = cpu_s; put_nz(cpu_x); end
      8'h9A: cpu_s = cpu_x;
      8'hCA: begin cpu_x = cpu_x - 8'd1; put_nz(cpu_x); end
      8'hE8: begin cpu_x = cpu_x + 8'd1; put_nz(cpu_x); end
      8'h88: begin cpu_y = cpu_y - 8'd1; put_nz(cpu_y); end
      8'hC8: begin cpu_y = cpu_y + 8'd1; put_nz(cpu_y); end
      8'h18: put_flag(FlC, 0);
      8'h38: put_flag(FlC, 1);
      8'h58: put_flag(FlI, 0);
      8'h78: put_flag(FlI, 1);
      8'hB8: put_flag(FlV, 0);
      8'hD8: put_flag(FlD, 0);
      8'hF8: put_flag(FlD, 1);
      default: ;
    endcase
  endfunction

  // operand access cycles at cpu_ea, k counts from the first access
  function automatic void operand_cycle(int k, logic [7:0] d, func_e f);
    kind_e kd;
    kd = access_kind(f);
    if (kd == K_READ) begin
      if (k == 0) rd(cpu_ea);
      else begin do_read(f, d); fetch_op(); end
    end else if (kd == K_WRITE) begin
      if (k == 0) wr(cpu_ea, (f == F_STA) ? cpu_a : ((f == F_STX) ? cpu_x : cpu_y));
      else fetch_op();
    end else begin
      if (k == 0) rd(cpu_ea);
      else if (k == 1) begin cpu_lat = d; wr(cpu_ea, d); end
      else if (k == 2) begin cpu_lat = shift_op(f, cpu_lat); wr(cpu_ea, cpu_lat); end
      else fetch_op();
    end
  endfunction

  function automatic void add_index(logic [7:0] hi, logic [7:0] idx);
    logic [8:0] sum;
    sum = {1'b0, cpu_ea[7:0]} + {1'b0, idx};
    page_cross = sum[8];
    cpu_ea = {hi, sum[7:0]};
    rd(cpu_ea);
  endfunction

  function automatic void indexed_cycle(int k, logic [7:0] d, func_e f);
    if (access_kind(f) == K_READ && !page_cross) begin
      operand_cycle(k + 1, d, f);
    end else begin
      if (k == 0 && page_cross) cpu_ea = cpu_ea + 16'h0100;
      operand_cycle(k, d, f);
    end
  endfunction

  function automatic void exec_cycle(logic [7:0] d);
    mode_e m;
    func_e f;
    int n;
    logic [2:0] a;
    bit taken;
    if (cpu_step == 3'd0) cpu_op = d;
    decode_op(cpu_op, m, f);
    cpu_step = cpu_step + 3'd1;
    n = cpu_step;
    a = cpu_op[7:5];
    case (m)
      M_IMP: if (n == 1) begin rd(cpu_pc); do_implied(cpu_op); end else fetch_op();
      M_IMM: if (n == 1) rd_pc(); else begin do_read(f, d); fetch_op(); end
      M_ZP: begin
        if (n == 1) rd_pc();
        else begin
          if (n == 2) cpu_ea = {8'h00, d};
          operand_cycle(n - 2, d, f);
        end
      end
      M_ZPX, M_ZPY: begin
        if (n == 1) rd_pc();
        else if (n == 2) begin
          rd({8'h00, d});
          cpu_ea = {8'h00, d + ((m == M_ZPX) ? cpu_x : cpu_y)};
        end else operand_cycle(n - 3, d, f);
      end
      M_ABS: begin
        if (n == 1) rd_pc();
        else if (n == 2) begin cpu_ea = {8'h00, d}; rd_pc(); end
        else begin
          if (n == 3) cpu_ea[15:8] = d;
          operand_cycle(n - 3, d, f);
        end
      end
      M_ABX, M_ABY: begin
        if (n == 1) rd_pc();
        else if (n == 2) begin cpu_ea = {8'h00, d}; rd_pc(); end
        else if (n == 3) add_index(d, (m == M_ABX) ? cpu_x : cpu_y);
        else indexed_cycle(n - 4, d, f);
      end
      M_IZX: begin
        if (n == 1) rd_pc();
        else if (n == 2) begin rd({8'h00, d}); cpu_lat = d + cpu_x; end
        else if (n == 3) rd({8'h00, cpu_lat});
        else if (n == 4) begin cpu_ea = {8'h00, d}; rd({8'h00, cpu_lat + 8'd1}); end
        else begin
          if (n == 5) cpu_ea[15:8] = d;
          operand_cycle(n - 5, d, f);
        end
      end
      M_IZY: begin
        if (n == 1) rd_pc();
        else if (n == 2) begin cpu_lat = d; rd({8'h00, d}); end
        else if (n == 3) begin cpu_ea = {8'h00, d}; rd({8'h00, cpu_lat + 8'd1}); end
        else if (n == 4) add_index(d, cpu_y);
        else indexed_cycle(n - 5, d, f);
      end
      M_REL: begin
        if (n == 1) rd_pc();
        else if (n == 2) begin
          case (a[2:1])
            2'd0: taken = cpu_p[7];
            2'd1: taken = cpu_p[6];
            2'd2: taken = cpu_p[0];
            default: taken = cpu_p[1];
          endcase
          if (taken != a[0]) fetch_op();
          else begin
            rd(cpu_pc);
            cpu_ea = cpu_pc + {{8{d[7]}}, d};
            page_cross = cpu_ea[15:8] != cpu_pc[15:8];
            cpu_pc = {cpu_pc[15:8], cpu_ea[7:0]};
          end
        end else if (n == 3 && page_cross) begin
          rd(cpu_pc);
          cpu_pc = cpu_ea;
        end else fetch_op();
      end
      M_BRK: begin
        if (n == 1) rd_pc();
        else if (n == 2) begin wr(sp_adr(), cpu_pc[15:8]); cpu_s = cpu_s - 8'd1; end
        else if (n == 3) begin wr(sp_adr(), cpu_pc[7:0]); cpu_s = cpu_s - 8'd1; end
        else if (n == 4) begin
          wr(sp_adr(), cpu_p | 8'h30);
          cpu_s = cpu_s - 8'd1;
          put_flag(FlI, 1);
        end else if (n == 5) rd(VecBrkLo);
        else if (n == 6) begin cpu_ea = {8'h00, d}; rd(VecBrkHi); end
        else begin cpu_pc = {d, cpu_ea[7:0]}; fetch_op(); end
      end
      M_JSR: begin
        if (n == 1) rd_pc();
        else if (n == 2) begin cpu_lat = d; rd(sp_adr()); end
        else if (n == 3) begin wr(sp_adr(), cpu_pc[15:8]); cpu_s = cpu_s - 8'd1; end
        else if (n == 4) begin wr(sp_adr(), cpu_pc[7:0]); cpu_s = cpu_s - 8'd1; end
        else if (n == 5) rd(cpu_pc);
        else begin cpu_pc = {d, cpu_lat}; fetch_op(); end
      end
      M_RTI: begin
        if (n == 1) rd(cpu_pc);
        else if (n == 2 || n == 3) begin rd(sp_adr()); cpu_s = cpu_s + 8'd1; end
        else if (n == 4) begin
          cpu_p = (d & 8'hCF) | 8'h20;
          rd(sp_adr());
          cpu_s = cpu_s + 8'd1;
        end else if (n == 5) begin cpu_ea = {8'h00, d}; rd(sp_adr()); end
        else begin cpu_pc = {d, cpu_ea[7:0]}; fetch_op(); end
      end
      M_RTS: begin
        if (n == 1) rd(cpu_pc);
        else if (n == 2 || n == 3) begin rd(sp_adr()); cpu_s = cpu_s + 8'd1; end
        else if (n == 4) begin cpu_ea = {8'h00, d}; rd(sp_adr()); end
        else if (n == 5) begin cpu_pc = {d, cpu_ea[7:0]}; rd_pc(); end
        else fetch_op();
      end
      M_PUSH: begin
        if (n == 1) rd(cpu_pc);
        else if (n == 2) begin
          wr(sp_adr(), (cpu_op == 8'h48) ? cpu_a : (cpu_p | 8'h30));
          cpu_s = cpu_s - 8'd1;
        end else fetch_op();
      end
      M_PULL: begin
        if (n == 1) rd(cpu_pc);
        else if (n == 2) begin rd(sp_adr()); cpu_s = cpu_s + 8'd1; end
        else if (n == 3) rd(sp_adr());
        else begin
          if (cpu_op == 8'h68) begin cpu_a = d; put_nz(d); end
          else cpu_p = (d & 8'hCF) | 8'h20;
          fetch_op();
        end
      end
      M_JMP: begin
        if (n == 1) rd_pc();
        else if (n == 2) begin cpu_lat = d; rd(cpu_pc); end
        else begin cpu_pc = {d, cpu_lat}; fetch_op(); end
      end
      default: begin // indirect jump: pointer high byte stays in its page
        if (n == 1) rd_pc();
        else if (n == 2) begin cpu_ea = {8'h00, d}; rd_pc(); end
        else if (n == 3) begin cpu_ea[15:8] = d; rd(cpu_ea); end
        else if (n == 4) begin
          cpu_lat = d;
          rd({cpu_ea[15:8], cpu_ea[7:0] + 8'd1});
        end else begin cpu_pc = {d, cpu_lat}; fetch_op(); end
      end
    endcase
  endfunction

  function automatic out_item_t next_access(in_item_t t);
    if (t.operation) cpu_clear();
    if (vec_ph == 1) begin
      rd(VecResLo);
      vec_ph = 2;
    end else if (vec_ph == 2) begin
      cpu_ea = {8'h00, t.read_data};
      rd(VecResHi);
      vec_ph = 3;
    end else if (vec_ph == 3) begin
      cpu_pc = {t.read_data, cpu_ea[7:0]};
      vec_ph = 0;
      fetch_op();
    end else exec_cycle(t.read_data);
    return bus_acc;
  endfunction

  // ---------------- stimulus ----------------
  logic [7:0] legal_ops[$];
  logic [7:0] dir_ops[$];

  initial begin
    in_item_t  t;
    out_item_t prev;
    mode_e     m;
    func_e     f;
    for (int op = 0; op < 256; op++) begin
      decode_op(8'(op), m, f);
      if (m != M_IMP || f != F_NONE ||
          op inside {8'h0A, 8'h2A, 8'h4A, 8'h6A, 8'h8A, 8'h98, 8'hAA, 8'hA8, 8'hBA,
                     8'h9A, 8'hCA, 8'hE8, 8'h88, 8'hC8, 8'h18, 8'h38, 8'h58, 8'h78,
                     8'hB8, 8'hD8, 8'hF8, 8'hEA})
        legal_ops.push_back(8'(op));
    end
    // ADC and SBC immediate, indirect jump, BRK, an illegal opcode
    dir_ops = '{8'h69, 8'h6C, 8'h00, 8'h02, 8'hE9};
    cpu_clear();
    prev = '0;
    for (int i = 0; i < NumTicks; i++) begin
      t = '0;
      if (i == 0) t.operation = 1'b1;
      else if (i >= NumDirected) t.operation = ($urandom_range(149) == 0);
      if (i < NumDirected) begin
        if (prev.opcode_fetch && dir_ops.size() > 0) t.read_data = dir_ops.pop_front();
        else t.read_data = i[0] ? 8'hFF : 8'h00;
      end else if (prev.opcode_fetch && $urandom_range(99) < 90) begin
        t.read_data = legal_ops[$urandom_range(legal_ops.size() - 1)];
      end else begin
        t.read_data = 8'($urandom);
      end
      prev = next_access(t);
      tick_q.push_back(t);
      access_q.push_back(prev);
    end

    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (tick_q.size() == 0 && access_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // phase 0: no random idling, 1: sender idle, 2: receiver stalls, 3: both, lightly
  function automatic int phase_of(int cnt);
    return (cnt * 4) / NumTicks;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int ph;
    bit idle;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      ph = phase_of(sent_cnt);
      idle = (ph == 1 && $urandom_range(99) < 82) || (ph == 3 && $urandom_range(99) < 17);
      if (in_valid_i) sent_cnt++;
      if (tick_q.size() > 0 && !idle) begin
        in_valid_i <= 1'b1;
        in_data_i <= tick_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  int hold_left = 0;
  bit hold_done = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_acc;
    int ph;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        seen_cnt++;
        if (access_q.size() == 0) begin
          $error("unexpected transaction: addr %h", out_data_o.bus_address);
          err_cnt++;
        end else begin
          exp_acc = access_q.pop_front();
          if (out_data_o.bus_address !== exp_acc.bus_address) begin
            $error("bus_address exp %h got %h", exp_acc.bus_address, out_data_o.bus_address);
            err_cnt++;
          end
          if (out_data_o.bus_write_data !== exp_acc.bus_write_data) begin
            $error("bus_write_data exp %h got %h", exp_acc.bus_write_data,
                   out_data_o.bus_write_data);
            err_cnt++;
          end
          if (out_data_o.bus_write !== exp_acc.bus_write) begin
            $error("bus_write exp %b got %b", exp_acc.bus_write, out_data_o.bus_write);
            err_cnt++;
          end
          if (out_data_o.opcode_fetch !== exp_acc.opcode_fetch) begin
            $error("opcode_fetch exp %b got %b", exp_acc.opcode_fetch, out_data_o.opcode_fetch);
            err_cnt++;
          end
        end
      end
      // long back-pressure stretch early on to fill the core
      if (!hold_done && seen_cnt == 60) begin
        hold_done = 1;
        hold_left = 300;
      end
      ph = phase_of(seen_cnt);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (ph == 2) out_ready_i <= ($urandom_range(99) >= 82);
      else if (ph == 3) out_ready_i <= ($urandom_range(99) >= 17);
      else out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

/* mos6502_cpu_core.f */
hdl/m6502_pkg.sv
hdl/m6502_exec.sv
hdl/mos6502_cpu_core.sv
tb/tb_top.sv
